// ===== sv/rlc_ode_pkg.sv =====
// ----------------------------------------------------------------------------
// RLC ODE integrator package
// Shared widths, register indexes, codes and the control structs that pass
// between the step sequencer and the shared scaling unit.
// ----------------------------------------------------------------------------
package rlc_ode_pkg;

  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int FIELD_W    = 32;
  localparam int H_W        = 24;
  localparam int RES_W      = 64;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_METHOD    = CFG_IDX_W'(1);

  localparam logic [1:0] METHOD_EULER = 2'd0;
  localparam logic [1:0] METHOD_AB2   = 2'd1;
  localparam logic [1:0] METHOD_RK4   = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [H_W-1:0] STEP_SIZE_RST = H_W'(6711);

  localparam int COEF_X = 500;
  localparam int COEF_Y = 5;
  localparam int COEF_Z = 5000;
  localparam int BIAS   = 5000;

  typedef struct packed {
    logic start;
    logic half;
    logic div6;
  } scale_ctl_t;

  typedef struct packed {
    logic                    done;
    logic signed [RES_W-1:0] value;
  } scale_res_t;

endpackage

// ===== sv/rlc_ode_step_integrator.sv =====
// ----------------------------------------------------------------------------
// RLC ODE step integrator
// Fixed-step Euler, two-step Adams-Bashforth or fourth-order Runge-Kutta
// integration of a three-state linear RLC system in signed fixed point.
// ----------------------------------------------------------------------------
// A load word is taken in idle and passes through the finish state to the output
// register. A step is taken in idle, then runs an evaluate state and, per axis,
// a scale and a wait state for each derivative pass, multiplying in N 32-bit chunks
// (N = 2 at the default width), and ends in the finish state: one pass for Euler and
// Adams-Bashforth and four for Runge-Kutta, whose final pass also divides by six.
// One word is in work at a time. Reset clears the state, sets h to 6711 and picks RK4.
module rlc_ode_step_integrator
  import rlc_ode_pkg::*;
#(
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [3*FIELD_W-1:0]   s_axis_tdata_i,   // x_in, y_in, z_in
  input  logic                   s_axis_tuser_i,   // operation
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [3*FIELD_W-1:0]   m_axis_tdata_o,   // x_out, y_out, z_out
  output logic                   m_axis_tuser_o    // saturated
);

  localparam int VW    = VALUE_WIDTH;
  localparam int DW    = VW + 16;
  localparam int SW    = DW + 3;
  localparam int SUM_W = RES_W + 1;

  localparam logic signed [SUM_W-1:0] VMAX = {{(SUM_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] VMIN = ~VMAX;
  localparam logic signed [DW-1:0]    K_X    = DW'(COEF_X);
  localparam logic signed [DW-1:0]    K_Y    = DW'(COEF_Y);
  localparam logic signed [DW-1:0]    K_Z    = DW'(COEF_Z);
  localparam logic signed [DW-1:0]    F_BIAS = DW'(BIAS) << FRACTION_BITS;

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_SCALE, S_WAIT, S_FIN} state_e;
  typedef enum logic [1:0] {M_EULER, M_AB2, M_RK4} mode_e;

  state_e                 state_q;
  logic [1:0]             ax_q, stage_q;
  logic                   hist_q, sat_q;
  logic [H_W-1:0]         step_size_q;
  logic [1:0]             method_q;
  logic                   m_valid_q, m_user_q;
  logic [3*FIELD_W-1:0]   m_data_q;
  logic signed [VW-1:0]   st_q   [3];
  logic signed [VW-1:0]   pt_q   [3];
  logic signed [DW-1:0]   k_q    [3];
  logic signed [DW-1:0]   k1_q   [3];
  logic signed [DW-1:0]   prev_q [3];
  logic signed [SW-1:0]   sum_q  [3];

  logic signed [DW-1:0]    d [3];
  logic [VW:0]             ld [3];
  mode_e                   mode;
  logic                    final_pass;
  logic signed [SW-1:0]    operand;
  scale_ctl_t              scale_ctl;
  scale_res_t              scale_res;
  logic signed [SUM_W-1:0] upd_sum;
  logic [VW:0]             upd;
  logic                    in_accept;
  logic                    out_load;

  function automatic logic [VW:0] clamp_fn(input logic signed [SUM_W-1:0] v);
    logic [VW:0] r;
    if (v > VMAX) begin
      r = {1'b1, VMAX[VW-1:0]};
    end else if (v < VMIN) begin
      r = {1'b1, VMIN[VW-1:0]};
    end else begin
      r = {1'b0, v[VW-1:0]};
    end
    return r;
  endfunction

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == S_FIN) && (!m_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  always_comb begin
    d[0] = F_BIAS - K_X * DW'(pt_q[0]) - K_Z * DW'(pt_q[2]);
    d[1] = K_Z * DW'(pt_q[2]) - K_Y * DW'(pt_q[1]);
    d[2] = DW'(pt_q[0]) - DW'(pt_q[1]);
    for (int i = 0; i < 3; i++) begin
      ld[i] = clamp_fn(SUM_W'($signed(s_axis_tdata_i[i*FIELD_W +: FIELD_W])));
    end

    unique case (method_q)
      METHOD_EULER: mode = M_EULER;
      METHOD_AB2:   mode = hist_q ? M_AB2 : M_EULER;
      default:      mode = M_RK4;
    endcase
    final_pass = (mode != M_RK4) || (stage_q == 2'd3);

    scale_ctl.start = (state_q == S_SCALE);
    unique case (mode)
      M_AB2: begin
        operand        = (SW'(k1_q[ax_q]) <<< 1) + SW'(k1_q[ax_q]) - SW'(prev_q[ax_q]);
        scale_ctl.half = 1'b1;
        scale_ctl.div6 = 1'b0;
      end
      M_RK4: begin
        if (stage_q == 2'd3) begin
          operand        = sum_q[ax_q];
          scale_ctl.half = 1'b0;
          scale_ctl.div6 = 1'b1;
        end else begin
          operand        = SW'(k_q[ax_q]);
          scale_ctl.half = (stage_q != 2'd2);
          scale_ctl.div6 = 1'b0;
        end
      end
      default: begin
        operand        = SW'(k_q[ax_q]);
        scale_ctl.half = 1'b0;
        scale_ctl.div6 = 1'b0;
      end
    endcase

    upd_sum = SUM_W'(st_q[ax_q]) + SUM_W'(scale_res.value);
    upd     = clamp_fn(upd_sum);
  end

  rlc_ode_scale #(
    .IN_W (SW)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scale_ctl),
    .operand_i   (operand),
    .step_size_i (step_size_q),
    .res_o       (scale_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ax_q        <= '0;
      stage_q     <= '0;
      hist_q      <= 1'b0;
      sat_q       <= 1'b0;
      step_size_q <= STEP_SIZE_RST;
      method_q    <= METHOD_RK4;
      m_valid_q   <= 1'b0;
      m_user_q    <= 1'b0;
      m_data_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        st_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_STEP_SIZE) begin
          step_size_q <= cfg_data_i[H_W-1:0];
        end else if (cfg_index_i == REG_METHOD) begin
          method_q <= cfg_data_i[1:0];
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
        m_user_q  <= sat_q;
        m_data_q  <= {FIELD_W'(st_q[2]), FIELD_W'(st_q[1]), FIELD_W'(st_q[0])};
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            stage_q <= '0;
            ax_q    <= '0;
            if (s_axis_tuser_i == OP_LOAD) begin
              for (int i = 0; i < 3; i++) begin
                st_q[i] <= $signed(ld[i][VW-1:0]);
              end
              sat_q   <= ld[0][VW] | ld[1][VW] | ld[2][VW];
              hist_q  <= 1'b0;
              state_q <= S_FIN;
            end else begin
              sat_q   <= 1'b0;
              state_q <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          ax_q    <= '0;
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (scale_res.done) begin
            if (final_pass) begin
              st_q[ax_q] <= $signed(upd[VW-1:0]);
              sat_q      <= sat_q | upd[VW];
            end
            if (ax_q == 2'd2) begin
              if (final_pass) begin
                hist_q  <= 1'b1;
                state_q <= S_FIN;
              end else begin
                stage_q <= stage_q + 2'd1;
                state_q <= S_EVAL;
              end
            end else begin
              ax_q    <= ax_q + 2'd1;
              state_q <= S_SCALE;
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_accept) begin
      for (int i = 0; i < 3; i++) begin
        pt_q[i] <= st_q[i];
      end
    end
    if (state_q == S_EVAL) begin
      for (int i = 0; i < 3; i++) begin
        k_q[i] <= d[i];
        if (stage_q == 2'd0) begin
          k1_q[i]  <= d[i];
          sum_q[i] <= SW'(d[i]);
        end else if (stage_q == 2'd3) begin
          sum_q[i] <= sum_q[i] + SW'(d[i]);
        end else begin
          sum_q[i] <= sum_q[i] + (SW'(d[i]) <<< 1);
        end
      end
    end
    if (state_q == S_WAIT && scale_res.done) begin
      if (!final_pass) begin
        pt_q[ax_q] <= $signed(upd[VW-1:0]);
      end else if (ax_q == 2'd2) begin
        for (int i = 0; i < 3; i++) begin
          prev_q[i] <= k1_q[i];
        end
      end
    end
  end

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_res.done |-> state_q == S_WAIT)
    else $error("Scaling unit finished outside of the wait state.");

  a_stage_rk4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && stage_q != 2'd0) |->
      (method_q != METHOD_EULER && method_q != METHOD_AB2))
    else $error("Runge-Kutta stage advanced under another method.");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_FIN))
    else $error("Output word raised outside of the finish state.");

endmodule

// ===== sv/rlc_ode_scale.sv =====
// ----------------------------------------------------------------------------
// RLC ODE shared scaling unit
// Multiplies a signed derivative by the step size one 32-bit chunk per cycle,
// rounds half away from zero at 2^-24 or 2^-25, caps the magnitude at 2^62
// and optionally divides by six with rounding, 16 quotient bits per cycle.
// ----------------------------------------------------------------------------
module rlc_ode_scale
  import rlc_ode_pkg::*;
#(
  parameter int IN_W = 51
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scale_ctl_t             ctl_i,
  input  logic signed [IN_W-1:0] operand_i,
  input  logic [H_W-1:0]         step_size_i,
  output scale_res_t             res_o
);

  localparam int CW         = 32;
  localparam int NCH        = (IN_W + CW - 1) / CW;
  localparam int MP         = NCH * CW;
  localparam int PW         = MP + H_W;
  localparam int CNT_W      = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int DIG_W      = 16;
  localparam int NDIG       = RES_W / DIG_W;
  localparam int DCNT_W     = $clog2(NDIG);
  localparam int T_W        = DIG_W + 2;
  localparam int PROD_W     = 2 * T_W;
  localparam int DIV3_MUL   = 174763;
  localparam int DIV3_SHIFT = 19;
  localparam int CAP_SHIFT  = 62;

  localparam logic [PW:0] RND24 = (PW+1)'(1) << (H_W - 1);
  localparam logic [PW:0] RND25 = (PW+1)'(1) << H_W;
  localparam logic [PW:0] CAP   = (PW+1)'(1) << CAP_SHIFT;

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_RND, U_DIV} ustate_e;

  ustate_e            ust_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic               neg_q, half_q, div6_q, done_q;
  logic [MP-1:0]      mag_q;
  logic [H_W-1:0]     h_q;
  logic [PW-1:0]      acc_q;
  logic [RES_W-1:0]   dv_q;
  logic [1:0]         rem_q;
  logic [RES_W-1:0]   res_q;

  logic [IN_W-1:0]     opnd_mag;
  logic [CW+H_W-1:0]   pp;
  logic [PW-1:0]       acc_next;
  logic [PW:0]         rsum, rq, rcap;
  logic [RES_W-1:0]    rmag, dvs, qfin;
  logic [T_W-1:0]      t, trem;
  logic [PROD_W-1:0]   tprod;
  logic [DIG_W-1:0]    q16;

  always_comb begin
    opnd_mag = operand_i[IN_W-1] ? IN_W'(-operand_i) : IN_W'(operand_i);
    pp       = (CW+H_W)'(mag_q[MP-1 -: CW]) * (CW+H_W)'(h_q);
    acc_next = (acc_q << CW) + PW'(pp);
    rsum     = {1'b0, acc_q} + (half_q ? RND25 : RND24);
    rq       = half_q ? (rsum >> (H_W + 1)) : (rsum >> H_W);
    rcap     = (rq > CAP) ? CAP : rq;
    rmag     = RES_W'(rcap);
    dvs      = (rmag + RES_W'(3)) >> 1;
    t        = {rem_q, dv_q[RES_W-1 -: DIG_W]};
    tprod    = PROD_W'(t) * PROD_W'(DIV3_MUL);
    q16      = tprod[DIV3_SHIFT +: DIG_W];
    trem     = t - T_W'(q16) * T_W'(3);
    qfin     = {dv_q[RES_W-DIG_W-1:0], q16};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ust_q  <= U_IDLE;
      cnt_q  <= '0;
      dcnt_q <= '0;
      neg_q  <= 1'b0;
      half_q <= 1'b0;
      div6_q <= 1'b0;
      done_q <= 1'b0;
      mag_q  <= '0;
      h_q    <= '0;
      acc_q  <= '0;
      dv_q   <= '0;
      rem_q  <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (ust_q)
        U_IDLE: begin
          if (ctl_i.start) begin
            mag_q  <= MP'(opnd_mag);
            neg_q  <= operand_i[IN_W-1];
            half_q <= ctl_i.half;
            div6_q <= ctl_i.div6;
            h_q    <= step_size_i;
            acc_q  <= '0;
            cnt_q  <= '0;
            ust_q  <= U_MUL;
          end
        end
        U_MUL: begin
          acc_q <= acc_next;
          mag_q <= mag_q << CW;
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(NCH - 1)) begin
            ust_q <= U_RND;
          end
        end
        U_RND: begin
          if (div6_q) begin
            dv_q   <= dvs;
            rem_q  <= '0;
            dcnt_q <= '0;
            ust_q  <= U_DIV;
          end else begin
            res_q  <= neg_q ? (RES_W'(0) - rmag) : rmag;
            done_q <= 1'b1;
            ust_q  <= U_IDLE;
          end
        end
        U_DIV: begin
          dv_q   <= qfin;
          rem_q  <= trem[1:0];
          dcnt_q <= dcnt_q + DCNT_W'(1);
          if (dcnt_q == DCNT_W'(NDIG - 1)) begin
            res_q  <= neg_q ? (RES_W'(0) - qfin) : qfin;
            done_q <= 1'b1;
            ust_q  <= U_IDLE;
          end
        end
        default: ust_q <= U_IDLE;
      endcase
    end
  end

  assign res_o.done  = done_q;
  assign res_o.value = $signed(res_q);

endmodule
